// ----- rtl/hfdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfdp_pkg: shared types and constants
// Queue entry layout, configuration register indexes and float constants of
// the 16-bit float dot-product accumulator.
// ----------------------------------------------------------------------------
package hfdp_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned CfgIdxW = 1;

	localparam logic [CfgIdxW-1:0] CfgElemFmt = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgResFmt  = 1'd1;

	localparam logic [31:0] CanonNan32 = 32'h7FC0_0000;
	localparam logic [31:0] PosZero32  = 32'h0000_0000;

	typedef struct packed {
		logic [31:0] prod;
		logic        last;
	} hfdp_entry_t;

endpackage
`default_nettype wire

// ----- rtl/half_float_dot_product_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// half_float_dot_product_accumulator: 16-bit float dot product, single sum
// Term pairs (bfloat16 or IEEE half) enter a four-stage product pipeline, a
// short queue, then a single-precision accumulator. A new pair is accepted
// every cycle while the queue has room; the accumulator takes a new term only
// after it has finished the last one, through the loop-carried add (align,
// add, normalize, round). For the last term of a dot product the sum is then
// converted and registered as the result, and the accumulator restarts at +0.
// ----------------------------------------------------------------------------
module half_float_dot_product_accumulator #(
	parameter int unsigned QueueDepth = hfdp_pkg::QueueDepth
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [hfdp_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic                         cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [15:0]                  hidden_bits,
	input  wire logic [15:0]                  weight_bits,
	input  wire logic                         last_term,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [31:0]                       result_bits
);

	logic element_format_q, result_format_q;
	logic f_valid, f_ready, q_valid, q_ready;
	hfdp_pkg::hfdp_entry_t f_entry, q_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_format_q <= 1'b0;
			result_format_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == hfdp_pkg::CfgElemFmt) element_format_q <= cfg_data;
			if (cfg_index == hfdp_pkg::CfgResFmt) result_format_q <= cfg_data;
		end
	end

	hfdp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.element_format (element_format_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.hidden_bits    (hidden_bits),
		.weight_bits    (weight_bits),
		.last_term      (last_term),
		.out_valid      (f_valid),
		.out_ready      (f_ready),
		.out_entry      (f_entry)
	);

	hfdp_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_entry),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_entry)
	);

	hfdp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.element_format (element_format_q),
		.result_format  (result_format_q),
		.in_valid       (q_valid),
		.in_ready       (q_ready),
		.in_entry       (q_entry),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_bits    (result_bits)
	);

endmodule
`default_nettype wire

// ----- rtl/hfdp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfdp_front: operand widening and product pipeline
// Accepts term pairs, widens both elements to normalized single form and
// forms their product rounded to single (nearest-even) over four stages.
// ----------------------------------------------------------------------------
module hfdp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 element_format,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [15:0]          hidden_bits,
	input  wire logic [15:0]          weight_bits,
	input  wire logic                 last_term,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output hfdp_pkg::hfdp_entry_t     out_entry
);

	typedef struct packed {
		logic               sign;
		logic               zero;
		logic               inf;
		logic               nan;
		logic signed [9:0]  exp;
		logic [23:0]        sig;
	} op_t;

	function automatic op_t unpack(input logic [15:0] b, input logic fmt);
		op_t        o;
		logic [9:0] m;
		logic [3:0] p;
		logic       emax;
		logic       ezero;
		o = '0;
		o.sign = b[15];
		m = fmt ? b[9:0] : {3'b000, b[6:0]};
		p = '0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) p = 4'(i);
		end
		emax = fmt ? (b[14:10] == 5'h1F) : (b[14:7] == 8'hFF);
		ezero = fmt ? (b[14:10] == 5'h00) : (b[14:7] == 8'h00);
		o.nan = emax && (m != '0);
		o.inf = emax && (m == '0);
		o.zero = ezero && (m == '0);
		if (ezero) begin
			o.sig = 24'({14'd0, m} << (5'd23 - 5'(p)));
			o.exp = fmt ? ($signed(10'(p)) - 10'sd24) : ($signed(10'(p)) - 10'sd133);
		end else if (fmt) begin
			o.sig = {1'b1, b[9:0], 13'd0};
			o.exp = $signed({5'd0, b[14:10]}) - 10'sd15;
		end else begin
			o.sig = {1'b1, b[6:0], 16'd0};
			o.exp = $signed({2'd0, b[14:7]}) - 10'sd127;
		end
		return o;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	op_t  a_s1, b_s1;
	logic last_s1;

	logic [47:0]       p_s2;
	logic signed [9:0] exp_s2;
	logic              sign_s2, nan_s2, inf_s2, zero_s2, last_s2;

	logic [47:0] q_s3;
	logic        sticky_s3, ovf_s3, sign_s3, nan_s3, inf_s3, zero_s3, last_s3;
	logic [7:0]  expf_s3;

	hfdp_pkg::hfdp_entry_t entry_s4;

	logic [47:0]       n3;
	logic signed [9:0] e3, ep3, shraw3;
	logic [5:0]        sh3;
	logic              normal3;
	logic [47:0]       q3;

	logic        rup4;
	logic [30:0] pk4;
	logic [31:0] prod4;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s4;
	assign out_entry = entry_s4;

	always_comb begin
		n3 = p_s2[47] ? p_s2 : {p_s2[46:0], 1'b0};
		e3 = exp_s2 + (p_s2[47] ? 10'sd1 : 10'sd0);
		ep3 = e3 + 10'sd127;
		normal3 = ep3 >= 10'sd1;
		shraw3 = 10'sd1 - ep3;
		if (normal3) sh3 = '0;
		else if (shraw3 > 10'sd50) sh3 = 6'd50;
		else sh3 = shraw3[5:0];
		q3 = n3 >> sh3;
	end

	always_comb begin
		rup4 = q_s3[23] && (q_s3[24] || (q_s3[22:0] != '0) || sticky_s3);
		pk4 = {expf_s3, q_s3[46:24]} + 31'(rup4);
		if (nan_s3) prod4 = hfdp_pkg::CanonNan32;
		else if (inf_s3 || ovf_s3) prod4 = {sign_s3, 8'hFF, 23'd0};
		else if (zero_s3) prod4 = {sign_s3, 31'd0};
		else prod4 = {sign_s3, pk4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			a_s1 <= unpack(hidden_bits, element_format);
			b_s1 <= unpack(weight_bits, element_format);
			last_s1 <= last_term;
		end
		if (v_s1 && rdy2) begin
			p_s2 <= a_s1.sig * b_s1.sig;
			exp_s2 <= a_s1.exp + b_s1.exp;
			sign_s2 <= a_s1.sign ^ b_s1.sign;
			nan_s2 <= a_s1.nan || b_s1.nan || (a_s1.inf && b_s1.zero)
				|| (a_s1.zero && b_s1.inf);
			inf_s2 <= a_s1.inf || b_s1.inf;
			zero_s2 <= a_s1.zero || b_s1.zero;
			last_s2 <= last_s1;
		end
		if (v_s2 && rdy3) begin
			q_s3 <= q3;
			sticky_s3 <= (48'(q3 << sh3) != n3);
			ovf_s3 <= ep3 >= 10'sd255;
			expf_s3 <= normal3 ? ep3[7:0] : 8'd0;
			sign_s3 <= sign_s2;
			nan_s3 <= nan_s2;
			inf_s3 <= inf_s2;
			zero_s3 <= zero_s2;
			last_s3 <= last_s2;
		end
		if (v_s3 && rdy4) begin
			entry_s4.prod <= prod4;
			entry_s4.last <= last_s3;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hfdp_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfdp_fifo: product queue
// Short first-in first-out queue of rounded products between the product
// pipeline and the accumulator.
// ----------------------------------------------------------------------------
module hfdp_fifo #(
	parameter int unsigned Depth = hfdp_pkg::QueueDepth
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	output logic                       push_ready,
	input  wire hfdp_pkg::hfdp_entry_t push_data,
	output logic                       pop_valid,
	input  wire logic                  pop_ready,
	output hfdp_pkg::hfdp_entry_t      pop_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	hfdp_pkg::hfdp_entry_t entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push, pop;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid = count_q != '0;
	assign pop_data = entries_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ----- rtl/hfdp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfdp_back: single-precision accumulator
// Adds each product into the running sum with a four-step float adder and
// emits the converted sum on the last term of a dot product.
// ----------------------------------------------------------------------------
module hfdp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  element_format,
	input  wire logic                  result_format,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire hfdp_pkg::hfdp_entry_t in_entry,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [31:0]                result_bits
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ADD   = 5'b00010,
		ST_NORM  = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

	function automatic logic [15:0] to_bf16(input logic [31:0] b);
		logic [31:0] t;
		if (b[30:23] == 8'hFF && b[22:0] != '0) return 16'h7FC0;
		t = b + 32'h7FFF + 32'(b[16]);
		return t[31:16];
	endfunction

	function automatic logic [15:0] to_half(input logic [31:0] b);
		logic              sign;
		logic [7:0]        ee;
		logic [22:0]       mm;
		logic signed [9:0] e;
		logic [15:0]       m;
		logic [12:0]       rem;
		logic [9:0]        shift;
		logic [23:0]       sig, rems, halfv, mask;
		sign = b[31];
		ee = b[30:23];
		mm = b[22:0];
		e = $signed({2'd0, ee}) - 10'sd127;
		if (ee == 8'hFF) return (mm != '0) ? 16'h7E00 : {sign, 15'h7C00};
		if (ee == 8'h00) return {sign, 15'd0};
		if (e > 10'sd15) return {sign, 15'h7C00};
		if (e >= -10'sd14) begin
			m = {1'b0, 5'(e + 10'sd15), mm[22:13]};
			rem = mm[12:0];
			if (rem > 13'h1000 || (rem == 13'h1000 && m[0])) m = m + 1'b1;
			return {sign, 15'd0} | m;
		end
		shift = 10'(-e - 10'sd1);
		if (shift >= 10'd25) return {sign, 15'd0};
		sig = {1'b1, mm};
		mask = (24'd1 << shift[4:0]) - 1'b1;
		m = 16'(sig >> shift[4:0]);
		rems = sig & mask;
		halfv = 24'd1 << (shift[4:0] - 1'b1);
		if (rems > halfv || (rems == halfv && m[0])) m = m + 1'b1;
		return {sign, 15'd0} | m;
	endfunction

	state_t state_q;
	logic [31:0] acc_q;
	logic [26:0] siga_q, sigb_q, norm_q;
	logic [27:0] sum_q;
	logic [8:0]  exp_q, nexp_q;
	logic        sign_q, sub_q, nan_q, inf_q, infsign_q, last_q, zero_q;
	logic        out_valid_q;
	logic [31:0] result_q;

	logic        pop;
	logic [31:0] a, b, big, minor;
	logic        ia, ib, na, nb;
	logic [8:0]  ebig, esmall;
	logic [8:0]  d;
	logic [26:0] bfull, bs;
	logic        st;

	logic [4:0]  lz;
	logic [8:0]  lim, sft;
	logic [26:0] nrm;
	logic [8:0]  nexp;

	logic [8:0]  expf;
	logic        rup;
	logic [30:0] pk;
	logic [31:0] sumbits;
	logic        emit_go;

	assign in_ready = state_q == ST_IDLE;
	assign pop = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign result_bits = result_q;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		a = acc_q;
		b = in_entry.prod;
		na = (a[30:23] == 8'hFF) && (a[22:0] != '0);
		nb = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		ia = (a[30:23] == 8'hFF) && (a[22:0] == '0);
		ib = (b[30:23] == 8'hFF) && (b[22:0] == '0);
		if (a[30:0] >= b[30:0]) begin
			big = a;
			minor = b;
		end else begin
			big = b;
			minor = a;
		end
		ebig = (big[30:23] == 8'h00) ? 9'd1 : {1'b0, big[30:23]};
		esmall = (minor[30:23] == 8'h00) ? 9'd1 : {1'b0, minor[30:23]};
		d = ebig - esmall;
		bfull = {minor[30:23] != 8'h00, minor[22:0], 3'b000};
		if (d >= 9'd27) begin
			bs = '0;
			st = bfull != '0;
		end else begin
			bs = bfull >> d;
			st = 27'(bs << d) != bfull;
		end
	end

	always_comb begin
		lz = lzc27(sum_q[26:0]);
		lim = exp_q - 1'b1;
		sft = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
		if (sum_q[27]) begin
			nrm = {sum_q[27:2], sum_q[1] | sum_q[0]};
			nexp = exp_q + 1'b1;
		end else begin
			nrm = 27'(sum_q[26:0] << sft);
			nexp = exp_q - sft;
		end
	end

	always_comb begin
		expf = norm_q[26] ? nexp_q : 9'd0;
		rup = norm_q[2] && (norm_q[3] || norm_q[1] || norm_q[0]);
		pk = {expf[7:0], norm_q[25:3]} + 31'(rup);
		if (nan_q) sumbits = hfdp_pkg::CanonNan32;
		else if (inf_q) sumbits = {infsign_q, 8'hFF, 23'd0};
		else if (zero_q) sumbits = {sign_q && !sub_q, 31'd0};
		else if (expf >= 9'd255) sumbits = {sign_q, 8'hFF, 23'd0};
		else sumbits = {sign_q, pk};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q <= hfdp_pkg::PosZero32;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) state_q <= ST_ADD;
				end
				ST_ADD: state_q <= ST_NORM;
				ST_NORM: state_q <= ST_ROUND;
				ST_ROUND: begin
					acc_q <= sumbits;
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_go) begin
						acc_q <= hfdp_pkg::PosZero32;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			siga_q <= {big[30:23] != 8'h00, big[22:0], 3'b000};
			sigb_q <= {bs[26:1], bs[0] | st};
			exp_q <= ebig;
			sign_q <= big[31];
			sub_q <= a[31] ^ b[31];
			nan_q <= na || nb || (ia && ib && (a[31] != b[31]));
			inf_q <= ia || ib;
			infsign_q <= ia ? a[31] : b[31];
			last_q <= in_entry.last;
		end
		if (state_q == ST_ADD) begin
			sum_q <= sub_q ? ({1'b0, siga_q} - {1'b0, sigb_q})
				: ({1'b0, siga_q} + {1'b0, sigb_q});
		end
		if (state_q == ST_NORM) begin
			norm_q <= nrm;
			nexp_q <= nexp;
			zero_q <= sum_q == '0;
		end
		if (emit_go) begin
			if (result_format) result_q <= acc_q;
			else if (element_format) result_q <= {16'd0, to_half(acc_q)};
			else result_q <= {16'd0, to_bf16(acc_q)};
		end
	end

endmodule
`default_nettype wire
